[sv/bba_pkg.sv]
// shared constants and command/status types of the buddy block allocator
// no dependencies; used by bba_ctrl, bba_datapath and the top level
`default_nettype none

package bba_pkg;

  localparam int unsigned MaxOrderDef = 10;
  localparam int unsigned ReqW        = 31;
  localparam int unsigned OffW        = 30;
  localparam int unsigned TotW        = 31;
  localparam int unsigned MbW         = 5;
  localparam int unsigned AoW         = 4;
  localparam int unsigned MbLimit     = 20;
  localparam int unsigned AddrBits    = 30;
  localparam int unsigned InDataW     = 64;
  localparam int unsigned OutDataW    = 96;

  localparam logic [MbW-1:0] MbReset = 5'd12;
  localparam logic [AoW-1:0] AoReset = 4'd10;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } bba_op_e;

  typedef enum logic {
    REG_MIN_BLOCK_LOG2 = 1'b0,
    REG_ARENA_ORDER    = 1'b1
  } bba_reg_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic cfg_we;
    logic init;
    logic t_inc;
    logic ord_done;
    logic set_fail;
    logic o_inc;
    logic o_dec;
    logic pop;
    logic take_unit;
    logic spush;
    logic alloc_done;
    logic idx_clr;
    logic idx_inc;
    logic scan_rd;
    logic sh_rd;
    logic sh_wr;
    logic merge;
    logic push;
    logic finish;
  } bba_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_free;
    logic req_ok;
    logic grow;
    logic o_gt_ao;
    logic cnt_zero;
    logic o_gt_t;
    logic o_lt_ao;
    logic idx_lt_n;
    logic hit;
    logic sh_more;
    logic out_busy;
  } bba_sts_t;

endpackage

`default_nettype wire

[sv/bba_ctrl.sv]
// sequencing state machine of the buddy block allocator
// depends on bba_pkg for the command and status structs
`default_nettype none

module bba_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_valid_i,
  input  wire logic            cfg_valid_i,
  input  wire bba_pkg::bba_sts_t sts_i,
  output bba_pkg::bba_cmd_t    cmd_o,
  output logic                 s_ready_o,
  output logic                 cfg_ready_o
);

  typedef enum logic [13:0] {
    ST_INIT     = 14'b00000000000001,
    ST_IDLE     = 14'b00000000000010,
    ST_ORD      = 14'b00000000000100,
    ST_SRCH     = 14'b00000000001000,
    ST_POPW     = 14'b00000000010000,
    ST_SPLIT    = 14'b00000000100000,
    ST_SPUSH    = 14'b00000001000000,
    ST_MLOOP    = 14'b00000010000000,
    ST_SCAN_RD  = 14'b00000100000000,
    ST_SCAN_CMP = 14'b00001000000000,
    ST_SH_RD    = 14'b00010000000000,
    ST_SH_WR    = 14'b00100000000000,
    ST_PUSH     = 14'b01000000000000,
    ST_FIN      = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;

  assign cfg_ready_o = (state_q == ST_IDLE);
  assign s_ready_o   = (state_q == ST_IDLE) && !cfg_valid_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = ST_IDLE;
      end
      ST_IDLE: begin
        if (cfg_valid_i) begin
          cmd_o.cfg_we = 1'b1;
          state_d      = ST_INIT;
        end else if (s_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_ORD;
        end
      end
      ST_ORD: begin
        if (!sts_i.req_ok) begin
          cmd_o.set_fail = 1'b1;
          state_d        = ST_FIN;
        end else if (sts_i.grow) begin
          cmd_o.t_inc = 1'b1;
        end else begin
          cmd_o.ord_done = 1'b1;
          state_d        = sts_i.is_free ? ST_MLOOP : ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (sts_i.o_gt_ao) begin
          cmd_o.set_fail = 1'b1;
          state_d        = ST_FIN;
        end else if (sts_i.cnt_zero) begin
          cmd_o.o_inc = 1'b1;
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = ST_POPW;
        end
      end
      ST_POPW: begin
        cmd_o.take_unit = 1'b1;
        state_d         = ST_SPLIT;
      end
      ST_SPLIT: begin
        if (sts_i.o_gt_t) begin
          cmd_o.o_dec = 1'b1;
          state_d     = ST_SPUSH;
        end else begin
          cmd_o.alloc_done = 1'b1;
          state_d          = ST_FIN;
        end
      end
      ST_SPUSH: begin
        cmd_o.spush = 1'b1;
        state_d     = ST_SPLIT;
      end
      ST_MLOOP: begin
        if (sts_i.o_lt_ao) begin
          cmd_o.idx_clr = 1'b1;
          state_d       = ST_SCAN_RD;
        end else begin
          state_d = ST_PUSH;
        end
      end
      ST_SCAN_RD: begin
        if (sts_i.idx_lt_n) begin
          cmd_o.scan_rd = 1'b1;
          state_d       = ST_SCAN_CMP;
        end else begin
          state_d = ST_PUSH;
        end
      end
      ST_SCAN_CMP: begin
        if (sts_i.hit) begin
          state_d = ST_SH_RD;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = ST_SCAN_RD;
        end
      end
      ST_SH_RD: begin
        if (sts_i.sh_more) begin
          cmd_o.sh_rd = 1'b1;
          state_d     = ST_SH_WR;
        end else begin
          cmd_o.merge = 1'b1;
          state_d     = ST_MLOOP;
        end
      end
      ST_SH_WR: begin
        cmd_o.sh_wr = 1'b1;
        state_d     = ST_SH_RD;
      end
      ST_PUSH: begin
        cmd_o.push = 1'b1;
        state_d    = ST_FIN;
      end
      ST_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // a finished item leaves once the output register is free
  a_fin_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FIN && !sts_i.out_busy |=> state_q == ST_IDLE)
    else $error("result not handed to output register");

  // an accepted item goes on to the order step
  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_valid_i && s_ready_o |=> state_q == ST_ORD)
    else $error("accepted item did not start");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register not one-hot");

endmodule

`default_nettype wire

[sv/bba_datapath.sv]
// datapath of the buddy block allocator: config, free-list memory, counts, totals
// depends on bba_pkg; driven by bba_ctrl commands
`default_nettype none

module bba_datapath #(
  parameter int unsigned MAX_ORDER = bba_pkg::MaxOrderDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire bba_pkg::bba_cmd_t             cmd_i,
  output bba_pkg::bba_sts_t                  sts_o,
  input  wire logic                          cfg_index_i,
  input  wire logic [bba_pkg::MbW-1:0]       cfg_data_i,
  input  wire logic                          in_cmd_i,
  input  wire logic [bba_pkg::ReqW-1:0]      in_req_i,
  input  wire logic [bba_pkg::OffW-1:0]      in_foff_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic                               out_ok_o,
  output logic [bba_pkg::OffW-1:0]           out_offset_o,
  output logic [bba_pkg::TotW-1:0]           out_used_o,
  output logic [bba_pkg::TotW-1:0]           out_reqt_o
);

  localparam int unsigned NumLists = MAX_ORDER + 1;
  localparam int unsigned LW       = $clog2(NumLists);
  localparam int unsigned OW       = $clog2(MAX_ORDER + 2);
  localparam int unsigned CW       = MAX_ORDER + 1;
  localparam int unsigned UW       = MAX_ORDER;
  localparam int unsigned AW       = LW + MAX_ORDER;
  localparam int unsigned Depth    = NumLists << MAX_ORDER;
  localparam logic [CW-1:0] Cap    = CW'(1) << MAX_ORDER;

  // config and request registers
  logic [bba_pkg::MbW-1:0]  mb_q;
  logic [bba_pkg::AoW-1:0]  aoc_q;
  logic                     op_q;
  logic [bba_pkg::ReqW-1:0] req_q;
  logic [bba_pkg::OffW-1:0] foff_q;

  // working registers
  logic [OW-1:0] o_q, o_d, t_q, t_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [UW-1:0] cur_q, cur_d;
  logic [CW-1:0] cnt_q [NumLists];
  logic [CW-1:0] cnt_d [NumLists];
  logic [bba_pkg::TotW-1:0] used_q, used_d, reqt_q, reqt_d;
  logic                     res_ok_q, res_ok_d;
  logic [bba_pkg::OffW-1:0] res_off_q, res_off_d;

  // memory
  logic [UW-1:0] mem [Depth];
  logic [UW-1:0] rd_q;
  logic          re, we;
  logic [AW-1:0] raddr, waddr;
  logic [UW-1:0] wdata;

  // effective configuration
  logic [4:0] m_eff, a_sat, a_eff;
  logic [5:0] ma_sum;
  logic [OW-1:0] ao_eff;

  always_comb begin
    m_eff  = (mb_q > 5'(bba_pkg::MbLimit)) ? 5'(bba_pkg::MbLimit) : mb_q;
    a_sat  = ({1'b0, aoc_q} > 5'(MAX_ORDER)) ? 5'(MAX_ORDER) : {1'b0, aoc_q};
    ma_sum = 6'(m_eff) + 6'(a_sat);
    a_eff  = (ma_sum > 6'(bba_pkg::AddrBits)) ? 5'(6'(bba_pkg::AddrBits) - 6'(m_eff))
                                               : a_sat;
    ao_eff = OW'(a_eff);
  end

  logic [31:0] arena_bytes, blk_bytes;
  logic [5:0]  mt_sum;
  logic        alloc_ok, free_ok;
  logic [CW-1:0] cnt_o;
  logic [UW-1:0] obit, buddy;
  logic          o_in_range;

  assign mt_sum      = 6'(m_eff) + 6'(t_q);
  assign arena_bytes = 32'(1) << (6'(m_eff) + 6'(a_eff));
  assign blk_bytes   = 32'(1) << mt_sum;
  assign alloc_ok    = (req_q != '0) && ({1'b0, req_q} <= arena_bytes);
  assign free_ok     = alloc_ok
                    && ((foff_q & ~(30'h3FFF_FFFF << m_eff)) == '0)
                    && ((32'(foff_q) >> m_eff) < (32'(1) << a_eff));
  assign o_in_range  = (o_q <= OW'(MAX_ORDER));
  assign cnt_o       = o_in_range ? cnt_q[o_q[LW-1:0]] : '0;
  assign obit        = UW'(1) << o_q;
  assign buddy       = cur_q ^ obit;

  always_comb begin
    sts_o.is_free  = (op_q == bba_pkg::CMD_FREE);
    sts_o.req_ok   = (op_q == bba_pkg::CMD_FREE) ? free_ok : alloc_ok;
    sts_o.grow     = blk_bytes < {1'b0, req_q};
    sts_o.o_gt_ao  = o_q > ao_eff;
    sts_o.cnt_zero = cnt_o == '0;
    sts_o.o_gt_t   = o_q > t_q;
    sts_o.o_lt_ao  = o_q < ao_eff;
    sts_o.idx_lt_n = idx_q < cnt_o;
    sts_o.hit      = rd_q == buddy;
    sts_o.sh_more  = ({1'b0, idx_q} + (CW+1)'(1)) < {1'b0, cnt_o};
    sts_o.out_busy = out_valid_o && !out_ready_i;
  end

  // memory port selection
  always_comb begin
    re    = cmd_i.pop || cmd_i.scan_rd || cmd_i.sh_rd;
    raddr = {o_q[LW-1:0], idx_q[MAX_ORDER-1:0]};
    if (cmd_i.pop) begin
      raddr = {o_q[LW-1:0], MAX_ORDER'(cnt_o - CW'(1))};
    end else if (cmd_i.sh_rd) begin
      raddr = {o_q[LW-1:0], MAX_ORDER'(idx_q + CW'(1))};
    end
    we    = 1'b0;
    waddr = {o_q[LW-1:0], cnt_o[MAX_ORDER-1:0]};
    wdata = cur_q;
    if (cmd_i.init) begin
      we    = 1'b1;
      waddr = {ao_eff[LW-1:0], MAX_ORDER'(0)};
      wdata = '0;
    end else if (cmd_i.spush) begin
      we    = cnt_o < Cap;
      wdata = cur_q + obit;
    end else if (cmd_i.push) begin
      we    = cnt_o < Cap;
    end else if (cmd_i.sh_wr) begin
      we    = 1'b1;
      waddr = {o_q[LW-1:0], idx_q[MAX_ORDER-1:0]};
      wdata = rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  always_comb begin
    o_d       = o_q;
    t_d       = t_q;
    idx_d     = idx_q;
    cur_d     = cur_q;
    cnt_d     = cnt_q;
    used_d    = used_q;
    reqt_d    = reqt_q;
    res_ok_d  = res_ok_q;
    res_off_d = res_off_q;
    if (cmd_i.cfg_we) begin
      for (int i = 0; i < NumLists; i++) begin
        cnt_d[i] = '0;
      end
      used_d = '0;
      reqt_d = '0;
    end
    if (cmd_i.init) begin
      cnt_d[ao_eff[LW-1:0]] = CW'(1);
    end
    if (cmd_i.accept) begin
      t_d = '0;
    end
    if (cmd_i.t_inc) begin
      t_d = t_q + OW'(1);
    end
    if (cmd_i.ord_done) begin
      o_d   = t_q;
      cur_d = UW'(32'(foff_q) >> m_eff);
      if (op_q == bba_pkg::CMD_FREE) begin
        used_d = used_q - (31'(1) << mt_sum);
        reqt_d = reqt_q - req_q;
      end
    end
    if (cmd_i.set_fail) begin
      res_ok_d  = 1'b0;
      res_off_d = '0;
    end
    if (cmd_i.o_inc) begin
      o_d = o_q + OW'(1);
    end
    if (cmd_i.o_dec) begin
      o_d = o_q - OW'(1);
    end
    if (cmd_i.pop) begin
      cnt_d[o_q[LW-1:0]] = cnt_o - CW'(1);
    end
    if (cmd_i.take_unit) begin
      cur_d = rd_q;
    end
    if ((cmd_i.spush || cmd_i.push) && (cnt_o < Cap)) begin
      cnt_d[o_q[LW-1:0]] = cnt_o + CW'(1);
    end
    if (cmd_i.alloc_done) begin
      used_d    = used_q + (31'(1) << mt_sum);
      reqt_d    = reqt_q + req_q;
      res_ok_d  = 1'b1;
      res_off_d = bba_pkg::OffW'(32'(cur_q) << m_eff);
    end
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end
    if (cmd_i.idx_inc || cmd_i.sh_wr) begin
      idx_d = idx_q + CW'(1);
    end
    if (cmd_i.merge) begin
      cnt_d[o_q[LW-1:0]] = cnt_o - CW'(1);
      cur_d = (buddy < cur_q) ? buddy : cur_q;
      o_d   = o_q + OW'(1);
    end
    if (cmd_i.push) begin
      res_ok_d  = 1'b1;
      res_off_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mb_q        <= bba_pkg::MbReset;
      aoc_q       <= bba_pkg::AoReset;
      for (int i = 0; i < NumLists; i++) begin
        cnt_q[i] <= '0;
      end
      used_q      <= '0;
      reqt_q      <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (cmd_i.cfg_we) begin
        if (cfg_index_i == bba_pkg::REG_MIN_BLOCK_LOG2) begin
          mb_q <= cfg_data_i;
        end else begin
          aoc_q <= cfg_data_i[bba_pkg::AoW-1:0];
        end
      end
      cnt_q  <= cnt_d;
      used_q <= used_d;
      reqt_q <= reqt_d;
      if (cmd_i.finish) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= in_cmd_i;
      req_q  <= in_req_i;
      foff_q <= in_foff_i;
    end
    o_q       <= o_d;
    t_q       <= t_d;
    idx_q     <= idx_d;
    cur_q     <= cur_d;
    res_ok_q  <= res_ok_d;
    res_off_q <= res_off_d;
    if (cmd_i.finish) begin
      out_ok_o     <= res_ok_q;
      out_offset_o <= res_off_q;
      out_used_o   <= used_q;
      out_reqt_o   <= reqt_q;
    end
  end

  // a push onto a full list never writes the memory
  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.spush || cmd_i.push) && cnt_o == Cap |-> !we)
    else $error("push written past list capacity");

  // splitting only happens above the target order
  a_split_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.o_dec |-> o_q > t_q)
    else $error("split below target order");

  // a config write re-initialises the totals
  a_cfg_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cfg_we |=> used_q == '0 && reqt_q == '0)
    else $error("totals not cleared by config write");

endmodule

`default_nettype wire

[sv/buddy_block_allocator.sv]
// top level of the binary buddy block allocator
// depends on bba_pkg, bba_ctrl and bba_datapath
`default_nettype none

// Binary buddy allocator over one arena of (1 << min_block_log2) << arena_order
// bytes. An item (tuser = 0 allocate, 1 free) is processed one at a time by a
// state machine walking per-order LIFO free lists kept in a single-port-write,
// single-port-read memory. An allocate first finds target order t, then searches
// upward for a non-empty list, pops a block and splits it down to t; a free
// scans each list from t upward for the buddy, shifts the entries behind it
// down and merges, and so the time it takes grows with list lengths. After
// reset and after every configuration write the block re-seeds the top free
// block before it takes an item. A finished result sits in an output register,
// so processing may finish while the previous result is still waiting; a result
// held back by the receiver stalls the next one until it has been taken.
module buddy_block_allocator #(
  parameter int unsigned MAX_ORDER = bba_pkg::MaxOrderDef
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [bba_pkg::InDataW-1:0]      s_axis_tdata,   // req_bytes, free_offset
  input  wire logic                             s_axis_tuser,   // cmd
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [bba_pkg::OutDataW-1:0]          m_axis_tdata,   // offset, used, requested
  output logic                                  m_axis_tuser,   // ok
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic                             cfg_index_i,
  input  wire logic [bba_pkg::MbW-1:0]          cfg_data_i
);

  bba_pkg::bba_cmd_t cmd;
  bba_pkg::bba_sts_t sts;

  logic [bba_pkg::OffW-1:0] out_offset;
  logic [bba_pkg::TotW-1:0] out_used, out_reqt;

  bba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .cfg_valid_i (cfg_valid_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .s_ready_o   (s_axis_tready),
    .cfg_ready_o (cfg_ready_o)
  );

  bba_datapath #(
    .MAX_ORDER (MAX_ORDER)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_cmd_i     (s_axis_tuser),
    .in_req_i     (s_axis_tdata[30:0]),
    .in_foff_i    (s_axis_tdata[60:31]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_ok_o     (m_axis_tuser),
    .out_offset_o (out_offset),
    .out_used_o   (out_used),
    .out_reqt_o   (out_reqt)
  );

  assign m_axis_tdata = {4'b0000, out_reqt, out_used, out_offset};

endmodule

`default_nettype wire

[sim/buddy_block_allocator_tb.sv]
// self-checking testbench of the buddy block allocator: directed and random
// allocate/free streams against a scoreboard with its own free-list predictor
// depends on bba_pkg and the buddy_block_allocator top level
`default_nettype none

module buddy_block_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bba_pkg::*;

  localparam int unsigned Orders  = MaxOrderDef + 1;
  localparam int unsigned ListCap = 1 << MaxOrderDef;
  localparam int unsigned CycleLimit = 3000000;

  typedef struct {
    bit        ok;
    bit [29:0] offset;
    bit [30:0] used;
    bit [30:0] requested;
  } alloc_res_t;

  class bba_scoreboard;
    alloc_res_t  pending[$];
    int unsigned errors;
    int unsigned fl_entry[Orders][ListCap];
    int unsigned fl_count[Orders];
    bit [30:0]   used_sum;
    bit [30:0]   req_sum;
    bit [4:0]    mb_reg;
    bit [3:0]    ao_reg;

    function new();
      mb_reg = MbReset;
      ao_reg = AoReset;
      errors = 0;
      seed_arena();
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function void limits(output int unsigned m, output int unsigned a);
      m = (mb_reg > MbLimit) ? MbLimit : mb_reg;
      a = (ao_reg > MaxOrderDef) ? MaxOrderDef : ao_reg;
      if (m + a > AddrBits) a = AddrBits - m;
    endfunction

    function void seed_arena();
      int unsigned m, a;
      limits(m, a);
      foreach (fl_count[o]) fl_count[o] = 0;
      used_sum = '0;
      req_sum  = '0;
      fl_entry[a][0] = 0;
      fl_count[a]    = 1;
    endfunction

    function void write_reg(bba_reg_e idx, bit [4:0] val);
      if (idx == REG_MIN_BLOCK_LOG2) mb_reg = val;
      else ao_reg = val[3:0];
      seed_arena();
    endfunction

    function void push_block(int unsigned o, int unsigned unit);
      if (fl_count[o] < ListCap) begin
        fl_entry[o][fl_count[o]] = unit;
        fl_count[o]++;
      end
    endfunction

    // removes the first match, the rest of the list keeps its order
    function bit take_buddy(int unsigned o, int unsigned unit);
      for (int unsigned i = 0; i < fl_count[o]; i++) begin
        if (fl_entry[o][i] == unit) begin
          for (int unsigned j = i; j + 1 < fl_count[o]; j++)
            fl_entry[o][j] = fl_entry[o][j+1];
          fl_count[o]--;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function int unsigned size_order(longint unsigned bytes, int unsigned m);
      longint unsigned sz;
      int unsigned o;
      sz = 64'd1 << m;
      o = 0;
      while (sz < bytes && o < 40) begin
        sz = sz << 1;
        o++;
      end
      return o;
    endfunction

    // accepted input: predict and queue its result
    function alloc_res_t note_input(bba_op_e cmd, bit [30:0] req, bit [29:0] foff);
      alloc_res_t r;
      int unsigned m, a, t, o, unit, cur, buddy;
      longint unsigned arena;
      limits(m, a);
      arena = 64'd1 << (m + a);
      r.ok = 0;
      r.offset = '0;
      if (cmd == CMD_ALLOC) begin
        if (req != 0 && req <= arena) begin
          t = size_order(req, m);
          o = t;
          while (o <= a && fl_count[o] == 0) o++;
          if (t <= a && o <= a) begin
            fl_count[o]--;
            unit = fl_entry[o][fl_count[o]];
            while (o > t) begin
              o--;
              push_block(o, unit + (1 << o));
            end
            used_sum = used_sum + 31'(32'd1 << (m + t));
            req_sum  = req_sum + req;
            r.ok = 1;
            r.offset = 30'(unit << m);
          end
        end
      end else if (req != 0 && req <= arena && (foff & ((32'd1 << m) - 1)) == 0 &&
                   (foff >> m) < (32'd1 << a)) begin
        t = size_order(req, m);
        o = t;
        cur = foff >> m;
        used_sum = used_sum - 31'(32'd1 << (m + t));
        req_sum  = req_sum - req;
        while (o < a) begin
          buddy = cur ^ (1 << o);
          if (!take_buddy(o, buddy)) break;
          if (buddy < cur) cur = buddy;
          o++;
        end
        push_block(o, cur);
        r.ok = 1;
      end
      r.used = used_sum;
      r.requested = req_sum;
      pending.insert(pending.size(), r);
      return r;
    endfunction

    task check_result(alloc_res_t got);
      alloc_res_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result ok=%0d off=%h", got.ok, got.offset));
        return;
      end
      e = pending.pop_front();
      if (got.ok != e.ok) report($sformatf("ok %0d want %0d", got.ok, e.ok));
      if (got.offset != e.offset) report($sformatf("offset %h want %h", got.offset, e.offset));
      if (got.used != e.used) report($sformatf("used %h want %h", got.used, e.used));
      if (got.requested != e.requested)
        report($sformatf("requested %h want %h", got.requested, e.requested));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = 1'b0;
  logic [MbW-1:0] cfg_data_i = '0;

  buddy_block_allocator u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  bba_scoreboard sb = new();
  int unsigned tx_pct = 0;
  int unsigned rx_pct = 0;
  bit hold_tgl = 0;
  int unsigned cycles = 0;

  // live allocations kept for well-formed frees
  bit [29:0] live_off[$];
  bit [30:0] live_req[$];

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver with random stalls and a long hold-off on request
  initial begin
    bit seen;
    int unsigned hold;
    seen = 0;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        alloc_res_t got;
        got.ok = m_axis_tuser;
        got.offset = m_axis_tdata[29:0];
        got.used = m_axis_tdata[60:30];
        got.requested = m_axis_tdata[91:61];
        sb.check_result(got);
      end
      if (hold_tgl != seen) begin
        seen = hold_tgl;
        hold = 3000;
      end
      if (hold != 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_pct);
      end
    end
  end

  task automatic send_item(bba_op_e cmd, bit [30:0] req, bit [29:0] foff);
    alloc_res_t r;
    while ($urandom_range(99) < tx_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {3'b000, foff, req};
    do @(posedge clk_i); while (!s_axis_tready);
    r = sb.note_input(cmd, req, foff);
    if (cmd == CMD_ALLOC && r.ok) begin
      live_off.insert(live_off.size(), r.offset);
      live_req.insert(live_req.size(), req);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_cfg(bba_reg_e idx, bit [4:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.write_reg(idx, val);
    live_off.delete();
    live_req.delete();
  endtask

  task automatic random_item();
    int unsigned m, a, r, lvl, k;
    sb.limits(m, a);
    r = $urandom_range(99);
    if (r < 55 || live_off.size() == 0) begin
      lvl = $urandom_range(0, (a < 4) ? a : 4);
      if ($urandom_range(19) == 0) lvl = a;
      send_item(CMD_ALLOC, 31'($urandom_range(32'd1 << (m + lvl), 1)), '0);
    end else if (r < 93) begin
      k = $urandom_range(live_off.size() - 1);
      send_item(CMD_FREE, live_req[k], live_off[k]);
      live_off.delete(k);
      live_req.delete(k);
    end else begin
      // noise: raw fields, mostly rejected or mismatched
      send_item(bba_op_e'($urandom_range(1)), 31'($urandom), 30'($urandom));
    end
  endtask

  initial begin
    bit [4:0] mb_set[5] = '{5'd20, 5'd31, 5'd12, 5'd16, 5'd12};
    bit [4:0] ao_set[5] = '{5'd10, 5'd15, 5'd0, 5'd5, 5'd10};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    tx_pct = 34;
    rx_pct = 53;

    // directed: arena is 4 MiB of 4 KiB blocks after reset
    send_item(CMD_ALLOC, 31'd0, '0);
    send_item(CMD_ALLOC, 31'h7fffffff, '0);
    send_item(CMD_ALLOC, 31'h40000000, '0);
    send_item(CMD_ALLOC, 31'h00400001, '0);
    send_item(CMD_ALLOC, 31'h00400000, '0);
    send_item(CMD_ALLOC, 31'd1, '0);            // no free block left
    send_item(CMD_FREE, 31'h00400000, 30'd0);
    send_item(CMD_ALLOC, 31'd1, '0);
    send_item(CMD_ALLOC, 31'd4097, '0);
    send_item(CMD_ALLOC, 31'd4096, '0);
    send_item(CMD_FREE, 31'd0, 30'd0);
    send_item(CMD_FREE, 31'h7fffffff, 30'd0);
    send_item(CMD_FREE, 31'd1, 30'd1);          // unaligned offset
    send_item(CMD_FREE, 31'd1, 30'h00400000);   // outside the arena
    send_item(CMD_FREE, 31'd1, 30'h3fffffff);
    send_item(CMD_FREE, 31'd4096, 30'h00003000);
    send_item(CMD_FREE, 31'd1, 30'd0);
    send_item(CMD_FREE, 31'd4097, 30'h00002000);
    send_item(CMD_FREE, 31'd1, 30'h00005000);   // mismatched free
    drain();

    for (int p = 0; p < 6; p++) begin
      if (p > 0) begin
        write_cfg(REG_MIN_BLOCK_LOG2, mb_set[p-1]);
        write_cfg(REG_ARENA_ORDER, ao_set[p-1]);
      end
      if (p == 2) begin tx_pct = 53; rx_pct = 34; end
      if (p == 4) begin tx_pct = 0; rx_pct = 0; end
      for (int i = 0; i < 50; i++) begin
        if (p == 1 && i == 20) hold_tgl = ~hold_tgl;
        if (p == 2 && i == 30) drain();
        random_item();
      end
      if (p == 5) begin
        // overfill the top list with mismatched top-order frees
        for (int i = 0; i < 1026; i++) send_item(CMD_FREE, 31'h00400000, 30'd0);
        for (int i = 0; i < 4; i++) send_item(CMD_ALLOC, 31'h00400000, '0);
      end
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
sv/bba_pkg.sv
sv/bba_ctrl.sv
sv/bba_datapath.sv
sv/buddy_block_allocator.sv
sim/buddy_block_allocator_tb.sv
